// File: rtl/urfl_pkg.sv
// shared types, widths and helpers for the ultrasonic range fir level block
// no dependencies; imported by urfl_mac and ultrasonic_range_fir_level
package urfl_pkg;

    localparam int WIDTH_W    = 16;   // echo width in us
    localparam int DIST_W     = 14;   // distance and cone height in mm
    localparam int COEF_W     = 16;   // signed q1.15 tap weight
    localparam int ACC_W      = 35;   // holds 8 * 2^15 * 16383 with sign
    localparam int FRAC_DROP  = 11;   // q.15 -> q.4
    localparam int FILT_W     = 22;
    localparam int WATER_W    = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int MAX_TAPS   = 8;
    localparam int TAP_SEL_W  = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 64;

    // floor(w*17/100) == (w * 17 * ceil(2^27/100)) >> 27 for every 16-bit w
    localparam int DIV_SHIFT  = 27;
    localparam int DIV_MULT_W = 25;
    localparam int DIV_PROD_W = WIDTH_W + DIV_MULT_W;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = 25'd22817026;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONE    = 2'd0,
        REG_COEF_LO = 2'd1,
        REG_COEF_HI = 2'd2
    } cfg_reg_t;

    // control from the sequencer to the shared multiply-accumulate unit
    typedef struct packed {
        logic clear;   // zero the accumulator
        logic issue;   // add the product of the presented operands into the accumulator
    } mac_ctrl_t;

    // pick tap n out of the two packed coefficient registers (high word on top)
    function automatic logic signed [COEF_W-1:0] coef_pick(
        input logic [2*CFG_DATA_W-1:0] taps,
        input logic [TAP_SEL_W-1:0]    n
    );
        logic [6:0] base;
        base = {n, 4'b0000};
        return taps[base +: COEF_W];
    endfunction

endpackage

// File: rtl/urfl_mac.sv
// shared multiply-accumulate unit: one coefficient times one sample per cycle
// product is registered, then added into the accumulator; uses urfl_pkg
module urfl_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  urfl_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [urfl_pkg::COEF_W-1:0]    coef,
    input  logic        [urfl_pkg::DIST_W-1:0]    sample,
    output logic signed [urfl_pkg::ACC_W-1:0]     acc
);
    import urfl_pkg::*;

    localparam int PROD_W = COEF_W + DIST_W + 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DIST_W:0]   sample_s;

    assign sample_s = signed'({1'b0, sample});

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(coef * sample_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= ctrl.issue;
            if (ctrl.clear)
                acc_reg <= '0;
            else if (prod_vld_reg)
                acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

// File: rtl/ultrasonic_range_fir_level.sv
// top level of the ultrasonic range fir level block: sequencer, sample ring,
// config registers and output register; uses urfl_pkg and urfl_mac
//
// usage
//   s_* channel: one transfer carries one echo width in us (s_tdata[15:0]).
//   m_* channel: one transfer per input carries the raw distance in mm, the
//   fir-filtered distance and the water height, both signed q.4 mm.
//   cfg_*: plain write port; index 0 cone height, 1 taps 0..3, 2 taps 4..7.
//   write it only while the block is idle.
// sequence
//   after an input transfer the block runs the width-to-mm multiply, then
//   clamp and ring write, then steps the shared multiply-accumulate unit over
//   the taps, then drains its product register and loads the result; only then
//   does it take the next input, as the single shared mac is busy until the
//   result is loaded. s_tready is high only while the sequencer idles.
// reset
//   rst_n clears the ring, write position, config registers and output valid.
// stall
//   a finished result waits in the output register; the next input is still
//   taken and computed, and only its final load waits for m_tready.
module ultrasonic_range_fir_level #(
    parameter int TAPS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [urfl_pkg::IN_DATA_W-1:0]      s_tdata,   // [15:0] echo_width_us
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [urfl_pkg::OUT_DATA_W-1:0]     m_tdata,   // [13:0] raw_distance_mm,
                                                           // [35:14] filtered_distance_q4,
                                                           // [58:36] water_height_q4, rest 0
    // configuration writes
    input  logic                                cfg_we,
    input  logic [urfl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [urfl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import urfl_pkg::*;

    localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);
    localparam int PAD_W = OUT_DATA_W - DIST_W - FILT_W - WATER_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CONV  = 6'b000010,
        ST_CLAMP = 6'b000100,
        ST_MAC   = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic [DIST_W-1:0]     cone_reg;
    logic [CFG_DATA_W-1:0] coef_lo_reg;
    logic [CFG_DATA_W-1:0] coef_hi_reg;

    // datapath registers
    logic [WIDTH_W-1:0]    width_reg;
    logic [DIST_W-1:0]     quot_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic [DIST_W-1:0]     hist_reg [TAPS];
    logic [IDX_W-1:0]      wpos_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [IDX_W-1:0]      tap_reg;
    logic                  out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [DIV_PROD_W-1:0]      div_prod;
    logic [DIST_W-1:0]          dist_clamped;
    logic                       out_load;
    mac_ctrl_t                  mac_ctrl;
    logic signed [COEF_W-1:0]   mac_coef;
    logic [DIST_W-1:0]          mac_sample;
    logic signed [ACC_W-1:0]    mac_acc;
    logic signed [FILT_W-1:0]   filt;
    logic signed [WATER_W-1:0]  water;

    // config write port, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cone_reg    <= '0;
            coef_lo_reg <= '0;
            coef_hi_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CONE:    cone_reg    <= cfg_wdata[DIST_W-1:0];
                REG_COEF_LO: coef_lo_reg <= cfg_wdata;
                REG_COEF_HI: coef_hi_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // width to mm by reciprocal multiply
    assign div_prod     = DIV_PROD_W'(width_reg) * DIV_PROD_W'(DIV_MULT);
    assign dist_clamped = (quot_reg > cone_reg) ? cone_reg : quot_reg;

    // result formatting: floor shift of the q.15 sum, then cone*16 minus it
    assign filt  = mac_acc[FRAC_DROP +: FILT_W];
    assign water = signed'({{(WATER_W - DIST_W - 4){1'b0}}, cone_reg, 4'b0000})
                 - signed'({filt[FILT_W-1], filt});

    assign out_load = (state_reg == ST_FIN) && (!out_vld_reg || m_tready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_CONV;
            ST_CONV:  state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_MAC;
            ST_MAC:   if (tap_reg == LAST_IDX) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_FIN;
            ST_FIN:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // mac operands and control
    assign mac_ctrl.clear = (state_reg == ST_CLAMP);
    assign mac_ctrl.issue = (state_reg == ST_MAC);
    assign mac_coef   = coef_pick({coef_hi_reg, coef_lo_reg}, TAP_SEL_W'(tap_reg));
    assign mac_sample = hist_reg[rd_idx_reg];

    // payload registers along the sequence
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            width_reg <= s_tdata[WIDTH_W-1:0];
        if (state_reg == ST_CONV)
            quot_reg <= div_prod[DIV_SHIFT +: DIST_W];
        if (state_reg == ST_CLAMP)
            dist_reg <= dist_clamped;
        if (out_load)
            out_data_reg <= {{PAD_W{1'b0}}, water, filt, dist_reg};
    end

    // sample ring and its pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
                hist_reg[i] <= '0;
            wpos_reg   <= '0;
            rd_idx_reg <= '0;
            tap_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                ST_CLAMP:
                begin
                    hist_reg[wpos_reg] <= dist_clamped;
                    rd_idx_reg         <= wpos_reg;
                    wpos_reg           <= (wpos_reg == LAST_IDX) ? '0 : wpos_reg + 1'b1;
                    tap_reg            <= '0;
                end
                ST_MAC:
                begin
                    // walk back from the newest sample
                    rd_idx_reg <= (rd_idx_reg == '0) ? LAST_IDX : rd_idx_reg - 1'b1;
                    tap_reg    <= tap_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_load)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    urfl_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .coef   (mac_coef),
        .sample (mac_sample),
        .acc    (mac_acc)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: sim/ultrasonic_range_fir_level_tb.sv
// self-checking testbench for ultrasonic_range_fir_level: echo widths in, range readings out
// depends on urfl_pkg and the rtl top level; a local predictor computes each reading
// a directed table runs first, then random phases with register changes between them
module ultrasonic_range_fir_level_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import urfl_pkg::*;

    localparam int TAP_COUNT   = 8;
    localparam int CYCLE_LIMIT = 500_000;   // far above the slowest correct run
    localparam int DRAIN_LIMIT = 4000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 125;

    // index with no register behind it, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // one reading as the block reports it
    typedef struct packed {
        logic [DIST_W-1:0]         raw_mm;
        logic signed [FILT_W-1:0]  filt_q4;
        logic signed [WATER_W-1:0] water_q4;
    } range_result_t;

    typedef enum logic {
        ROW_ECHO = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    // one row of the directed table: either a register write or an echo width,
    // with the reading typed in where it is obvious
    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_IDX_W-1:0]      reg_index;
        logic [CFG_DATA_W-1:0]     data;
        logic                      typed;
        logic [DIST_W-1:0]         raw_mm;
        logic signed [FILT_W-1:0]  filt_q4;
        logic signed [WATER_W-1:0] water_q4;
    } dir_row_t;

    localparam int DIR_ROWS = 34;
    localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
        // straight out of reset: cone height 0 clamps everything, taps are zero
        '{ROW_ECHO, REG_CONE, 64'd0,     1'b1, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd65535, 1'b1, 14'd0, 22'sd0, 23'sd0},
        // tallest cone, single tap at -1.0
        '{ROW_CFG,  REG_CONE,    64'd16383,             1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_CFG,  REG_COEF_LO, 64'h0000_0000_0000_8000, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd65535, 1'b1, 14'd11140, -22'sd178240, 23'sd440368},
        '{ROW_ECHO, REG_CONE, 64'd0,     1'b1, 14'd0,     22'sd0,       23'sd262128},
        // every tap at -1.0, then fill the whole ring with the longest echo
        '{ROW_CFG,  REG_COEF_LO, 64'h8000_8000_8000_8000, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_CFG,  REG_COEF_HI, 64'h8000_8000_8000_8000, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd65535, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd65535, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd65535, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd65535, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd65535, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd65535, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd65535, 1'b0, 14'd0, 22'sd0, 23'sd0},
        // ring now full of 11140: most negative filter output
        '{ROW_ECHO, REG_CONE, 64'd65535, 1'b1, 14'd11140, -22'sd1425920, 23'sd1688048},
        // every tap at the largest positive weight
        '{ROW_CFG,  REG_COEF_LO, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_CFG,  REG_COEF_HI, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd65535, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd65534, 1'b0, 14'd0, 22'sd0, 23'sd0},
        // small cone: two widths just above the clamp point and one just below it
        '{ROW_CFG,  REG_CONE, 64'd100, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd600, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd599, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd588, 1'b0, 14'd0, 22'sd0, 23'sd0},
        // lower cone while the ring still holds samples clamped at the old one
        '{ROW_CFG,  REG_CONE, 64'd50,  1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd300, 1'b0, 14'd0, 22'sd0, 23'sd0},
        // write to the unused index must leave every register alone
        '{ROW_CFG,  REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd100,     1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'h0000_AAAA, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'h0000_5555, 1'b0, 14'd0, 22'sd0, 23'sd0},
        // mixed signs and magnitudes across the taps
        '{ROW_CFG,  REG_COEF_LO, 64'h7FFF_8000_0001_FFFF, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_CFG,  REG_COEF_HI, 64'h0000_4000_C000_7FFF, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd65535, 1'b0, 14'd0, 22'sd0, 23'sd0},
        '{ROW_ECHO, REG_CONE, 64'd1,     1'b0, 14'd0, 22'sd0, 23'sd0}
    };

    // dut inputs all start at known values
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   m_tready  = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_CONE;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [OUT_DATA_W-1:0]  m_tdata;

    // predictor copy of the registers and the sample ring
    logic [DIST_W-1:0]      cone_mm = '0;
    logic [CFG_DATA_W-1:0]  coef_lo = '0;
    logic [CFG_DATA_W-1:0]  coef_hi = '0;
    logic [DIST_W-1:0]      history [TAP_COUNT];
    int unsigned            wr_slot = 0;

    range_result_t          pending_readings [$];   // readings owed by the block, oldest first
    int unsigned            mismatches  = 0;
    int unsigned            cycle_count = 0;
    logic                   calm        = 1'b0;     // no idling on either side while set

    ultrasonic_range_fir_level #(
        .TAPS      (TAP_COUNT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [15:0] echo_width_us
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [13:0] raw_distance_mm, [35:14] filtered_distance_q4,
                                  // [58:36] water_height_q4, [63:59] zero
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < TAP_COUNT; i++)
        begin
            history[i] = '0;
        end
    end

    // one line per mismatch, and a running count
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        mismatches++;
    endtask

    // distance, clamp, ring write and fir sum for one echo width
    function automatic range_result_t predict_reading(input logic [WIDTH_W-1:0] width_us);
        range_result_t              reading;
        int unsigned                mm;
        int unsigned                slot;
        int                         n;
        logic [2*CFG_DATA_W-1:0]    taps;
        logic signed [COEF_W-1:0]   weight;
        longint                     acc;
        longint                     filt;
        longint                     water;
        mm = (32'(width_us) * 32'd17) / 32'd100;
        if (mm > cone_mm)
        begin
            mm = cone_mm;
        end
        slot          = wr_slot;
        history[slot] = mm[DIST_W-1:0];
        wr_slot       = (slot + 1) % TAP_COUNT;
        // tap n weights the sample n steps back, tap 0 is the one just written
        taps = {coef_hi, coef_lo};
        acc  = 0;
        for (n = 0; n < TAP_COUNT; n++)
        begin
            weight = taps[n*COEF_W +: COEF_W];
            acc += longint'(weight) * longint'(history[(slot + TAP_COUNT - n) % TAP_COUNT]);
        end
        // q.15 to q.4, rounding toward minus infinity
        filt  = acc >>> FRAC_DROP;
        water = longint'(cone_mm) * 16 - filt;
        reading.raw_mm   = mm[DIST_W-1:0];
        reading.filt_q4  = filt[FILT_W-1:0];
        reading.water_q4 = water[WATER_W-1:0];
        return reading;
    endfunction

    // register write, one cycle of enable, then the predictor copy is updated once enable is low
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_CONE:    cone_mm = value[DIST_W-1:0];
            REG_COEF_LO: coef_lo = value;
            REG_COEF_HI: coef_hi = value;
            default:     ;
        endcase
    endtask

    // offer one echo width and hold it until the transfer; typed readings
    // replace the predicted one but the predictor still advances its ring
    task automatic push_echo(input logic [WIDTH_W-1:0] width_us, input logic use_typed,
                             input range_result_t typed);
        range_result_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= width_us;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = predict_reading(width_us);
        pending_readings.push_back(use_typed ? typed : predicted);
        // occasional sender gap of random length so inputs land on every phase
        if (!calm && $urandom_range(0, 99) < 6)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    endtask

    // block is idle once every reading has come out and the pipeline has drained
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAP_COUNT + 4) @(posedge clk);
    endtask

    // receiver stalls at random, about 6 percent of the time, never while calm
    always @(posedge clk)
    begin
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 6);
    end

    // result checker: each reading transfer against the oldest one owed
    always @(posedge clk)
    begin
        range_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_readings.size() == 0)
            begin
                report_mismatch("reading with none expected, raw", m_tdata[13:0], -1);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (m_tdata[13:0] !== want.raw_mm)
                    report_mismatch("raw_distance_mm", m_tdata[13:0], want.raw_mm);
                if (m_tdata[35:14] !== want.filt_q4)
                    report_mismatch("filtered_distance_q4", longint'($signed(m_tdata[35:14])),
                                    longint'(want.filt_q4));
                if (m_tdata[58:36] !== want.water_q4)
                    report_mismatch("water_height_q4", longint'($signed(m_tdata[58:36])),
                                    longint'(want.water_q4));
                if (m_tdata[63:59] !== '0)
                    report_mismatch("tdata padding", m_tdata[63:59], 0);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ultrasonic_range_fir_level verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned            row;
        int unsigned            phase;
        int unsigned            item;
        int unsigned            drain_wait;
        int                     t;
        int                     tap_style;
        int                     pick;
        int                     edge_w;
        int                     near_w;
        logic [DIST_W-1:0]      phase_cone;
        logic [COEF_W-1:0]      tap_val;
        logic [2*CFG_DATA_W-1:0] tap_words;
        logic [WIDTH_W-1:0]     width_us;
        range_result_t          typed;

        // reset once at the start, then released
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (row = 0; row < DIR_ROWS; row++)
        begin
            if (DIRECTED[row].kind == ROW_CFG)
            begin
                settle_block();
                write_register(DIRECTED[row].reg_index, DIRECTED[row].data);
            end
            else
            begin
                typed.raw_mm   = DIRECTED[row].raw_mm;
                typed.filt_q4  = DIRECTED[row].filt_q4;
                typed.water_q4 = DIRECTED[row].water_q4;
                push_echo(DIRECTED[row].data[WIDTH_W-1:0], DIRECTED[row].typed, typed);
            end
        end

        // random phases, registers changed only between them
        typed = '0;
        for (phase = 0; phase < PHASES; phase++)
        begin
            settle_block();
            // the first two phases pin the extremes of cone and taps
            if (phase < 2)
            begin
                phase_cone = 14'd16383;
                tap_style  = phase;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:       phase_cone = 14'd0;
                    1:       phase_cone = 14'd16383;
                    2:       phase_cone = 14'($urandom_range(1, 400));
                    default: phase_cone = 14'($urandom_range(0, 16383));
                endcase
                tap_style = $urandom_range(0, 5);
            end
            for (t = 0; t < TAP_COUNT; t++)
            begin
                case (tap_style)
                    0:       tap_val = 16'h8000;                    // all -1.0
                    1:       tap_val = 16'h7FFF;                    // all just under +1.0
                    2:       tap_val = 16'h0000;
                    3:       tap_val = 16'h1000;                    // plain moving average
                    4:       tap_val = 16'($urandom);
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0:       tap_val = 16'h8000;
                            1:       tap_val = 16'h7FFF;
                            2:       tap_val = 16'h0000;
                            default: tap_val = 16'($urandom);
                        endcase
                    end
                endcase
                tap_words[t*COEF_W +: COEF_W] = tap_val;
            end
            write_register(REG_CONE, {50'd0, phase_cone});
            write_register(REG_COEF_LO, tap_words[CFG_DATA_W-1:0]);
            write_register(REG_COEF_HI, tap_words[2*CFG_DATA_W-1:CFG_DATA_W]);
            if ($urandom_range(0, 3) == 0)
            begin
                write_register(REG_UNUSED, {$urandom, $urandom});
            end

            // a long stretch with no idling on either side
            calm = (phase == 4 || phase == 5);

            for (item = 0; item < PHASE_ITEMS; item++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    width_us = 16'($urandom_range(0, 65535));
                end
                else if (pick < 80)
                begin
                    // around the width where the clamp starts
                    edge_w = (int'(cone_mm) * 100) / 17;
                    near_w = edge_w + $urandom_range(0, 40) - 20;
                    if (near_w < 0)
                        near_w = 0;
                    if (near_w > 65535)
                        near_w = 65535;
                    width_us = near_w[WIDTH_W-1:0];
                end
                else
                begin
                    width_us = 16'($urandom_range(0, 300));
                end
                push_echo(width_us, 1'b0, typed);
            end
            calm = 1'b0;
        end

        // wait out the last readings, then let the pipeline run dry
        s_tvalid <= 1'b0;
        drain_wait = 0;
        while (pending_readings.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        if (pending_readings.size() != 0)
        begin
            report_mismatch("readings never delivered", pending_readings.size(), 0);
        end
        repeat (TAP_COUNT + 8) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("ultrasonic_range_fir_level verification clean");
        end
        else
        begin
            $display("ultrasonic_range_fir_level verification failed");
        end
        $finish;
    end

endmodule
